// ===== rtl/core/gce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gce_pkg
// Shared types, constants and the table function of the Gaussian covariance core.
// ----------------------------------------------------------------------------
package gce_pkg;

	// Port widths fixed by the interface.
	localparam int DATA_W = 32;
	localparam int COV_W  = 33;
	localparam int IDX_W  = 2;

	// Default fraction and table sizes.
	localparam int FRAC_BITS_DEF = 16;
	localparam int TBL_BITS_DEF  = 8;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_SILL   = 2'd0;
	localparam logic [IDX_W-1:0] REG_NUGGET = 2'd1;
	localparam logic [IDX_W-1:0] REG_RANGE  = 2'd2;

	// Fixed point constants in Q.30.
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;
	localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

	// Control that travels with each item down the pipeline.
	typedef struct packed {
		logic vld;
		logic row_end;
		logic zero;
	} gce_tag_t;

	// Entry i of the table of 2^(-i/2^tb) in Q.30, by a truncated Taylor series.
	function automatic logic [30:0] exp_tbl_entry(int unsigned i, int unsigned tb);
		logic [63:0] x;
		logic [63:0] sum;
		logic [63:0] term;
		x    = (64'(i) * 64'(LN2_Q30)) >> tb;
		sum  = 64'(ONE_Q30);
		term = 64'(ONE_Q30);
		for (int n = 1; n <= 16; n++) begin
			term = ((term * x) >> 30) / 64'(n);
			if (n[0])
				sum = sum - term;
			else
				sum = sum + term;
		end
		return sum[30:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gce_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gce_div
// Pipelined restoring divider for the lag to range ratio, one quotient bit per stage.
// ----------------------------------------------------------------------------
module gce_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire gce_pkg::gce_tag_t         in_tag,
	input  wire logic [gce_pkg::DATA_W-1:0] lag,
	input  wire logic [gce_pkg::DATA_W-1:0] rng,
	output gce_pkg::gce_tag_t              out_tag,
	output logic [FRAC_BITS+1:0]           quo
);
	import gce_pkg::*;

	localparam int UW  = FRAC_BITS + 2;
	localparam int NST = UW;

	gce_tag_t          tag_s [NST+1];
	logic [DATA_W-1:0] rem_s [NST+1];
	logic [UW-1:0]     q_s   [NST+1];
	logic [1:0]        hl_s  [NST+1];

	// Entry stage: a ratio of four or more underflows the exponential.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_s[0] <= '0;
		else if (en) begin
			tag_s[0] <= '{vld: in_tag.vld, row_end: in_tag.row_end,
			              zero: ({2'b00, lag} >= {rng, 2'b00})};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {2'b00, lag[DATA_W-1:2]};
			q_s[0]   <= '0;
			hl_s[0]  <= lag[1:0];
		end
	end

	// One trial subtraction per stage.
	for (genvar i = 0; i < NST; i++) begin : g_stage
		logic          nbit;
		logic [DATA_W:0]   sh;
		logic [DATA_W+1:0] diff;
		logic          ge;

		if (i == 0) begin : g_b1
			assign nbit = hl_s[i][1];
		end else if (i == 1) begin : g_b0
			assign nbit = hl_s[i][0];
		end else begin : g_bz
			assign nbit = 1'b0;
		end

		assign sh   = {rem_s[i], nbit};
		assign diff = {1'b0, sh} - {2'b00, rng};
		assign ge   = !diff[DATA_W+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				tag_s[i+1] <= '0;
			else if (en)
				tag_s[i+1] <= tag_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? diff[DATA_W-1:0] : sh[DATA_W-1:0];
				q_s[i+1]   <= {q_s[i][UW-2:0], ge};
				hl_s[i+1]  <= hl_s[i];
			end
		end
	end

	assign out_tag = tag_s[NST];
	assign quo     = q_s[NST];

endmodule
`default_nettype wire

// ===== rtl/core/gce_exp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gce_exp
// Pipelined exp(-3 u^2) by range reduction with ln2, a table and a linear correction.
// ----------------------------------------------------------------------------
module gce_exp #(
	parameter int FRAC_BITS      = 16,
	parameter int EXP_TABLE_BITS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire gce_pkg::gce_tag_t in_tag,
	input  wire logic [FRAC_BITS+1:0] u,
	output gce_pkg::gce_tag_t      out_tag,
	output logic [FRAC_BITS:0]     e
);
	import gce_pkg::*;

	localparam int F   = FRAC_BITS;
	localparam int TB  = EXP_TABLE_BITS;
	localparam int UW  = F + 2;
	localparam int TW  = F + 6;
	localparam int YW  = F + 7;
	localparam int KW  = YW - F;
	localparam int RW  = 32 - TB;
	localparam int DW  = 30 - TB;
	localparam int TSZ = 1 << TB;

	// Table of 2^(-i/2^TB), constant logic.
	logic [30:0] tbl [TSZ];
	for (genvar g = 0; g < TSZ; g++) begin : g_tbl
		assign tbl[g] = exp_tbl_entry(g, TB);
	end

	gce_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
		end else if (en) begin
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
		end
	end

	// Square of the ratio, then t = 3 u^2 in Q.F.
	logic [2*UW-1:0] uu_s1;
	logic [2*UW+1:0] uu3;
	logic [TW-1:0]   t_s2;
	assign uu3 = {2'b00, uu_s1} + {1'b0, uu_s1, 1'b0};

	// Scale by log2(e).
	logic [TW+30:0] yp;
	logic [YW-1:0]  y_s3;
	assign yp = t_s2 * LOG2E_Q30;

	// Split into integer exponent, table index and remainder.
	logic [31:0]    frac32;
	logic [RW-1:0]  remf;
	logic [RW+29:0] dp;
	logic [KW-1:0]  k_s4, k_s5;
	logic [TB-1:0]  idx_s4;
	logic [DW-1:0]  d_s4;
	assign frac32 = {y_s3[F-1:0], {(32-F){1'b0}}};
	assign remf   = frac32[RW-1:0];
	assign dp     = remf * LN2_Q30;

	// Table value times the linear correction.
	logic [30:0] om;
	logic [61:0] mp;
	logic [30:0] m_s5;
	assign om = ONE_Q30 - {{(31-DW){1'b0}}, d_s4};
	assign mp = tbl[idx_s4] * om;

	// Final shift by the integer exponent.
	logic       kbig;
	logic [7:0] s_full;
	logic [30:0] msh;
	logic [F:0] e_s6;
	assign kbig   = (8'(k_s5) > 8'(F));
	assign s_full = 8'(30 - F) + 8'(k_s5);
	assign msh    = m_s5 >> s_full[4:0];

	always_ff @(posedge clk) begin
		if (en) begin
			uu_s1  <= u * u;
			t_s2   <= uu3[TW+F-1:F];
			y_s3   <= yp[TW+30:30];
			k_s4   <= y_s3[YW-1:F];
			idx_s4 <= frac32[31:RW];
			d_s4   <= dp[RW+29:32];
			k_s5   <= k_s4;
			m_s5   <= mp[60:30];
			e_s6   <= (tag_s5.zero || kbig) ? '0 : msh[F:0];
		end
	end

	assign out_tag = tag_s6;
	assign e       = e_s6;

endmodule
`default_nettype wire

// ===== rtl/core/gce_mix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gce_mix
// Scales the exponential by the partial sill, adds twice the nugget and saturates.
// ----------------------------------------------------------------------------
module gce_mix #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire gce_pkg::gce_tag_t          in_tag,
	input  wire logic [FRAC_BITS:0]         e,
	input  wire logic [gce_pkg::DATA_W-1:0] sill,
	input  wire logic [gce_pkg::DATA_W-1:0] nugget,
	output gce_pkg::gce_tag_t               out_tag,
	output logic [gce_pkg::COV_W-1:0]       cov
);
	import gce_pkg::*;

	localparam int F  = FRAC_BITS;
	localparam int PW = DATA_W + F + 1;

	gce_tag_t tag_s1, tag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (en) begin
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
		end
	end

	// Magnitude of the partial sill and its sign.
	logic              neg;
	logic [DATA_W-1:0] psill;
	assign neg   = (nugget > sill);
	assign psill = neg ? (nugget - sill) : (sill - nugget);

	logic [PW-1:0] prod_s1;
	logic          neg_s1;

	// Sum with twice the nugget, saturated to the output width.
	logic [COV_W:0]   sum;
	logic [COV_W-1:0] cov_s2;
	assign sum = neg_s1 ? ({1'b0, nugget, 1'b0} - {1'b0, prod_s1[PW-1:F]})
	                    : ({1'b0, nugget, 1'b0} + {1'b0, prod_s1[PW-1:F]});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= psill * e;
			neg_s1  <= neg;
			cov_s2  <= sum[COV_W] ? {COV_W{1'b1}} : sum[COV_W-1:0];
		end
	end

	assign out_tag = tag_s2;
	assign cov     = cov_s2;

endmodule
`default_nettype wire

// ===== rtl/core/gaussian_covariance_eval_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_covariance_eval_core
// Streams Gaussian model covariances, one lag distance in and one value out.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    lag_distance, row_end
//  out      source     out_valid / out_ready  covariance, row_end_out
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle enters unless the output is held. There are FRAC_BITS + 2
// divider stages, one entry stage, six exponential and two output stages.
// The divider stages, one quotient bit each, set the depth.
// Reset clears the valid bits and loads the register defaults.
// A stalled output freezes every stage at once; nothing is dropped or repeated.
module gaussian_covariance_eval_core #(
	parameter int FRAC_BITS      = gce_pkg::FRAC_BITS_DEF,
	parameter int EXP_TABLE_BITS = gce_pkg::TBL_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [gce_pkg::DATA_W-1:0] lag_distance,
	input  wire logic                       row_end,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [gce_pkg::COV_W-1:0]       covariance,
	output logic                            row_end_out,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [gce_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [gce_pkg::DATA_W-1:0] cfg_data
);
	import gce_pkg::*;

	logic [DATA_W-1:0] sill_q, nugget_q, range_q, rng;

	// Configuration registers; unknown indexes are ignored.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sill_q   <= 32'h0001_0000;
			nugget_q <= '0;
			range_q  <= 32'h0001_0000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SILL:   sill_q   <= cfg_data;
				REG_NUGGET: nugget_q <= cfg_data;
				REG_RANGE:  range_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	// A zero range counts as one least significant bit.
	assign rng = (range_q == '0) ? {{(DATA_W-1){1'b0}}, 1'b1} : range_q;

	// Global advance: the whole pipeline moves unless the output is held.
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	gce_tag_t in_tag, div_tag, exp_tag, mix_tag;
	logic [FRAC_BITS+1:0] u;
	logic [FRAC_BITS:0]   e;

	assign in_tag = '{vld: in_valid, row_end: row_end, zero: 1'b0};

	gce_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk, .arst_n, .en,
		.in_tag, .lag(lag_distance), .rng,
		.out_tag(div_tag), .quo(u)
	);

	gce_exp #(.FRAC_BITS(FRAC_BITS), .EXP_TABLE_BITS(EXP_TABLE_BITS)) u_exp (
		.clk, .arst_n, .en,
		.in_tag(div_tag), .u,
		.out_tag(exp_tag), .e
	);

	gce_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
		.clk, .arst_n, .en,
		.in_tag(exp_tag), .e, .sill(sill_q), .nugget(nugget_q),
		.out_tag(mix_tag), .cov(covariance)
	);

	assign out_valid   = mix_tag.vld;
	assign row_end_out = mix_tag.row_end;

endmodule
`default_nettype wire

// ===== rtl/core/gce_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gce_checker
// Port level checks of the covariance core, bound to the top level.
// ----------------------------------------------------------------------------
module gce_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [32:0] covariance,
	input wire logic        row_end_out,
	input wire logic        cfg_ready
);

	// A held result keeps its value until the transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(covariance) && $stable(row_end_out))
		else $error("held result changed");

	// The input side stalls only while a result waits on the output.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// With a free output the input is always taken.
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready with empty output");

	// Configuration transfers are never refused.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind gaussian_covariance_eval_core gce_checker u_gce_checker (.*);
`default_nettype wire

// ===== tb/tb_gaussian_covariance_eval_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaussian_covariance_eval_core
// Self-checking bench for the Gaussian covariance core. Lag distances are sent
// over the valid/ready input, and every returned covariance is compared with a
// bit-exact fixed point predictor kept in the bench. The run walks through
// several register settings under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_gaussian_covariance_eval_core;
	import gce_pkg::*;

	localparam int FRAC    = FRAC_BITS_DEF;
	localparam int TBITS   = TBL_BITS_DEF;
	localparam int LAT     = FRAC + 11;
	localparam logic [63:0] COV_SAT = (64'd1 << COV_W) - 1;
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic [COV_W-1:0] cov;
		logic             re;
	} cov_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [DATA_W-1:0]   lag_distance = '0;
	logic                row_end = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [COV_W-1:0]    covariance;
	logic                row_end_out;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [DATA_W-1:0]   cfg_data = '0;

	gaussian_covariance_eval_core dut (.*);

	// Predictor copy of the registers and the table of 2^(-i/2^TBITS).
	logic [31:0]  sill_q = 32'd65536;
	logic [31:0]  nugget_q = 32'd0;
	logic [31:0]  range_q = 32'd65536;
	logic [63:0]  pow2_frac [1 << TBITS];
	cov_result_t  cov_expected_q [$];
	int           fail_count = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	int           hold_cycles = 0;

	// Clock generation.
	initial begin
		forever #10 clk = ~clk;
	end

	// Taylor series of exp(-x), x in Q.30, truncating after each term.
	function automatic logic [63:0] exp_neg_series(logic [63:0] x);
		logic [63:0] acc;
		logic [63:0] term;
		acc = 64'd1 << 30;
		term = 64'd1 << 30;
		for (int n = 1; n <= 16; n++) begin
			term = ((term * x) >> 30) / 64'(n);
			if (n % 2 == 1)
				acc = acc - term;
			else
				acc = acc + term;
		end
		return acc;
	endfunction

	// Expected covariance for lag h under the current register settings.
	function automatic logic [COV_W-1:0] predict_covariance(logic [31:0] h);
		logic [63:0] r, u, t, y, k, fr, idx, rem, d, m, s, e, cov;
		r = (range_q == 0) ? 64'd1 : 64'(range_q);
		u = (64'(h) << FRAC) / r;
		if (u >= (64'd4 << FRAC)) begin
			e = 0;
		end else begin
			t = (3 * u * u) >> FRAC;
			y = (t * 64'(LOG2E_Q30)) >> 30;
			k = y >> FRAC;
			fr = (y & ((64'd1 << FRAC) - 1)) << (32 - FRAC);
			idx = fr >> (32 - TBITS);
			rem = fr & ((64'd1 << (32 - TBITS)) - 1);
			d = (rem * 64'(LN2_Q30)) >> 32;
			m = (pow2_frac[idx] * ((64'd1 << 30) - d)) >> 30;
			s = 30 - FRAC + k;
			e = (s > 30) ? 64'd0 : (m >> s);
		end
		if (sill_q >= nugget_q)
			cov = 2 * 64'(nugget_q) + ((64'(sill_q - nugget_q) * e) >> FRAC);
		else
			cov = 2 * 64'(nugget_q) - ((64'(nugget_q - sill_q) * e) >> FRAC);
		if (cov > COV_SAT)
			cov = COV_SAT;
		return cov[COV_W-1:0];
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// Receiver: random or held-off ready, changed at the falling edge.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Result checker: each output transfer is matched with the oldest expectation.
	always @(posedge clk) begin
		cov_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (cov_expected_q.size() == 0) begin
				report_mismatch("unexpected result", 64'(covariance), 0);
			end else begin
				want = cov_expected_q.pop_front();
				if (covariance !== want.cov)
					report_mismatch("covariance", 64'(covariance), 64'(want.cov));
				if (row_end_out !== want.re)
					report_mismatch("row_end_out", 64'(row_end_out), 64'(want.re));
			end
		end
	end

	// Send one lag; each cycle the input idles with the set percentage first.
	task automatic send_lag(logic [31:0] h, logic re);
		cov_result_t want;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		lag_distance <= h;
		row_end <= re;
		do @(posedge clk); while (!in_ready);
		want.cov = predict_covariance(h);
		want.re = re;
		cov_expected_q.push_back(want);
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (cov_expected_q.size() != 0) @(posedge clk);
		repeat (LAT + 5) @(negedge clk);
	endtask

	// Register write; only issued once the pipeline is empty.
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
		wait_drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SILL:   sill_q = val;
			REG_NUGGET: nugget_q = val;
			REG_RANGE:  range_q = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_model(logic [31:0] s, logic [31:0] n, logic [31:0] r);
		write_reg(REG_SILL, s);
		write_reg(REG_NUGGET, n);
		write_reg(REG_RANGE, r);
	endtask

	// Lag drawn mostly inside four ranges, where the exponential is live.
	function automatic logic [31:0] pick_lag();
		logic [63:0] lim;
		lim = 64'(range_q) * 4;
		if (lim > 64'hFFFF_FFFF)
			lim = 64'hFFFF_FFFF;
		if ($urandom_range(9) < 8)
			return 32'($urandom_range(0, 32'(lim)));
		return $urandom;
	endfunction

	// Defaults after reset, extreme lags and the unused register index.
	task automatic test_directed();
		send_lag(32'd0, 1'b0);
		send_lag(32'd32768, 1'b1);
		send_lag(32'd262143, 1'b0);
		send_lag(32'd262144, 1'b1);
		send_lag(32'hFFFF_FFFF, 1'b0);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		send_lag(32'd65536, 1'b1);
		// Nugget above sill, then both at full scale.
		set_model(32'd1000, 32'd200000, 32'd65536);
		send_lag(32'd0, 1'b0);
		send_lag(32'd40000, 1'b1);
		send_lag(32'hFFFF_FFFF, 1'b0);
		set_model(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_lag(32'd0, 1'b1);
		send_lag(32'hFFFF_FFFF, 1'b0);
		set_model(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		send_lag(32'd0, 1'b1);
		send_lag(32'hFFFF_FFFF, 1'b0);
		send_lag(32'h7FFF_FFFF, 1'b1);
		// Zero range acts as one least significant bit.
		write_reg(REG_RANGE, 32'd0);
		send_lag(32'd0, 1'b0);
		send_lag(32'd1, 1'b1);
		send_lag(32'd3, 1'b0);
		send_lag(32'd4, 1'b1);
	endtask

	// Random settings, each followed by a burst of lags.
	task automatic test_random(int sets, int per_set);
		for (int i = 0; i < sets; i++) begin
			set_model($urandom, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 65536),
				($urandom_range(1) == 0) ? $urandom_range(1, 1 << 20) : $urandom);
			for (int j = 0; j < per_set; j++)
				send_lag(pick_lag(), 1'($urandom_range(1)));
		end
	endtask

	// Long receiver hold-off while lags keep coming, so the input stalls.
	task automatic test_backpressure();
		set_model(32'd98304, 32'd4096, 32'd131072);
		send_idle_pct = 0;
		@(negedge clk);
		hold_cycles = 200;
		for (int j = 0; j < 80; j++)
			send_lag(pick_lag(), 1'($urandom_range(1)));
		wait_drain();
	endtask

	initial begin
		for (int i = 0; i < (1 << TBITS); i++)
			pow2_frac[i] = exp_neg_series((64'(i) * 64'(LN2_Q30)) >> TBITS);
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		test_directed();
		send_idle_pct = 10;
		recv_idle_pct = 48;
		test_random(12, 30);
		send_idle_pct = 48;
		recv_idle_pct = 10;
		test_random(12, 30);
		test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(12, 30);

		wait_drain();
		if (fail_count == 0 && cov_expected_q.size() == 0)
			$display("gaussian_covariance_eval_core test passed");
		else
			$display("gaussian_covariance_eval_core test failed");
		$finish;
	end

	// Watchdog.
	initial begin
		#40_000_000;
		$display("gaussian_covariance_eval_core test failed");
		$finish;
	end

endmodule
